>>> design/srsw_pkg.sv
package srsw_pkg;

  // Default geometry
  localparam int unsigned SEQ_BITS_DEF     = 4;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  // Window size register
  localparam int unsigned      WIN_BITS  = 4;
  localparam logic [WIN_BITS-1:0] WIN_RESET = 4'd4;

  // Transaction kinds on the input channel
  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_EXPIRY = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // Timer service requests
  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_e;

  // Control sequencer
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

endpackage

>>> design/srsw_ifs.sv
// Input channel: one transaction per send request, ack or timer expiry
interface srsw_item_if #(
  parameter int unsigned SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [SEQ_BITS-1:0]     ack_number;
  logic                    checksum_ok;
  logic [SEQ_BITS-1:0]     expired_seq;

  modport source (output valid, kind, payload, ack_number, checksum_ok, expired_seq,
                  input ready);
  modport sink   (input valid, kind, payload, ack_number, checksum_ok, expired_seq,
                  output ready);
endinterface

// Result channel: one transaction per accepted input transaction
interface srsw_result_if #(
  parameter int unsigned SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic                    transmit;
  logic [SEQ_BITS-1:0]     tx_seq;
  logic [PAYLOAD_BITS-1:0] tx_payload;
  logic [1:0]              timer_action;
  logic [SEQ_BITS-1:0]     timer_seq;
  logic                    window_full;
  logic [SEQ_BITS-1:0]     window_base;

  modport source (output valid, accepted, transmit, tx_seq, tx_payload, timer_action,
                  timer_seq, window_full, window_base,
                  input ready);
  modport sink   (input valid, accepted, transmit, tx_seq, tx_payload, timer_action,
                  timer_seq, window_full, window_base,
                  output ready);
endinterface

>>> design/srsw_ram.sv
module srsw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/selective_repeat_sender_window.sv
// Flow: an accepted input transaction is registered and the sequencer enters execution;
//   the result register loads once the base has slid past each marked entry after an ack at
//   the window base (at most the window size) and the output slot is free. A new transaction
//   is taken only once the sequencer is back in idle, after the registered read of the
//   packet RAM and the result hand-over; a result held at the output stalls the next one.
// Reset: base, next sequence number, full flag and ack marks cleared, window size 4.
module selective_repeat_sender_window #(
  parameter int unsigned SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srsw_pkg::WIN_BITS-1:0] cfg_wdata_i,
  srsw_item_if.sink                     in_i,
  srsw_result_if.source                 res_o
);

  import srsw_pkg::*;

  localparam int unsigned SPACE = 1 << SEQ_BITS;
  localparam int unsigned HALF  = 1 << (SEQ_BITS - 1);
  localparam int unsigned CW    = (SEQ_BITS > WIN_BITS) ? SEQ_BITS : WIN_BITS;

  // Configuration and window state
  logic [WIN_BITS-1:0]     window_q;
  logic [SEQ_BITS-1:0]     base_q, base_d;
  logic [SEQ_BITS-1:0]     next_q, next_d;
  logic                    full_q, full_d;
  logic [SPACE-1:0]        marks_q, marks_d;
  state_e                  state_q, state_d;

  // Transaction in flight
  logic                    it_acc_q, it_acc_d;
  logic                    it_tx_q, it_tx_d;
  logic                    it_exp_q, it_exp_d;
  logic [SEQ_BITS-1:0]     it_seq_q, it_seq_d;
  logic [PAYLOAD_BITS-1:0] it_payload_q, it_payload_d;
  timer_e                  it_tmr_q, it_tmr_d;
  logic                    slide_q, slide_d;
  logic [SEQ_BITS-1:0]     cnt_q, cnt_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic                    out_acc_q, out_acc_d;
  logic                    out_tx_q, out_tx_d;
  logic [SEQ_BITS-1:0]     out_tx_seq_q, out_tx_seq_d;
  logic [PAYLOAD_BITS-1:0] out_payload_q, out_payload_d;
  timer_e                  out_tmr_q, out_tmr_d;
  logic [SEQ_BITS-1:0]     out_tmr_seq_q, out_tmr_seq_d;
  logic                    out_full_q, out_full_d;
  logic [SEQ_BITS-1:0]     out_base_q, out_base_d;

  // Packet RAM ports
  logic                    ram_we, ram_re;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  // Datapath helpers
  logic [CW-1:0]           win_ext, win_clamp;
  logic [SEQ_BITS-1:0]     win;
  logic [SEQ_BITS-1:0]     ack_off, outstanding, next_inc, next_off;
  logic                    acc_fire, scan_go, slot_free, load;

  // Effective window: zero acts as one, clamp to half the sequence space
  assign win_ext   = CW'(window_q);
  assign win_clamp = (win_ext == '0) ? CW'(1) :
                     (win_ext > CW'(HALF)) ? CW'(HALF) : win_ext;
  assign win       = win_clamp[SEQ_BITS-1:0];

  assign ack_off     = in_i.ack_number - base_q;
  assign outstanding = next_q - base_q;
  assign next_inc    = next_q + 1'b1;
  assign next_off    = next_inc - base_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign acc_fire   = in_i.valid && in_i.ready;
  assign scan_go    = slide_q && (cnt_q < win) && marks_q[base_q];
  assign slot_free  = !out_valid_q || res_o.ready;
  assign load       = (state_q == ST_EXEC) && !scan_go && slot_free;

  // Packet store
  srsw_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SPACE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (next_q),
    .wdata_i (in_i.payload),
    .re_i    (ram_re),
    .raddr_i (in_i.expired_seq),
    .rdata_o (ram_rdata)
  );

  // Sequencer: accept and update state, then slide / fetch and hand over the result
  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    next_d       = next_q;
    full_d       = full_q;
    marks_d      = marks_q;
    it_acc_d     = it_acc_q;
    it_tx_d      = it_tx_q;
    it_exp_d     = it_exp_q;
    it_seq_d     = it_seq_q;
    it_payload_d = it_payload_q;
    it_tmr_d     = it_tmr_q;
    slide_d      = slide_q;
    cnt_d        = cnt_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (acc_fire) begin
          state_d      = ST_EXEC;
          it_acc_d     = 1'b0;
          it_tx_d      = 1'b0;
          it_exp_d     = 1'b0;
          it_seq_d     = '0;
          it_payload_d = '0;
          it_tmr_d     = TMR_NONE;
          slide_d      = 1'b0;
          cnt_d        = '0;
          unique case (kind_e'(in_i.kind))
            KIND_SEND: begin
              if (!full_q) begin
                ram_we           = 1'b1;
                marks_d[next_q]  = 1'b0;
                it_acc_d         = 1'b1;
                it_tx_d          = 1'b1;
                it_seq_d         = next_q;
                it_payload_d     = in_i.payload;
                it_tmr_d         = TMR_START;
                next_d           = next_inc;
                full_d           = (next_off >= win);
              end
            end
            KIND_ACK: begin
              if (in_i.checksum_ok && (ack_off < win) && (ack_off < outstanding)) begin
                marks_d[in_i.ack_number] = 1'b1;
                it_tmr_d                 = TMR_STOP;
                it_seq_d                 = in_i.ack_number;
                if (in_i.ack_number == base_q) begin
                  slide_d = 1'b1;
                  full_d  = 1'b0;
                end
              end
            end
            KIND_EXPIRY: begin
              ram_re   = 1'b1;
              it_tx_d  = 1'b1;
              it_exp_d = 1'b1;
              it_seq_d = in_i.expired_seq;
              it_tmr_d = TMR_RESTART;
            end
            KIND_UNUSED: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_EXEC: begin
        // one marked entry per cycle leaves the window
        if (scan_go) begin
          marks_d[base_q] = 1'b0;
          base_d          = base_q + 1'b1;
          cnt_d           = SEQ_BITS'(cnt_q + 1'b1);
        end else if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register loads when the transaction finishes and the slot is free
  always_comb begin
    out_valid_d   = out_valid_q;
    out_acc_d     = out_acc_q;
    out_tx_d      = out_tx_q;
    out_tx_seq_d  = out_tx_seq_q;
    out_payload_d = out_payload_q;
    out_tmr_d     = out_tmr_q;
    out_tmr_seq_d = out_tmr_seq_q;
    out_full_d    = out_full_q;
    out_base_d    = out_base_q;
    if (load) begin
      out_valid_d   = 1'b1;
      out_acc_d     = it_acc_q;
      out_tx_d      = it_tx_q;
      out_tx_seq_d  = it_tx_q ? it_seq_q : '0;
      out_payload_d = !it_tx_q ? '0 : (it_exp_q ? ram_rdata : it_payload_q);
      out_tmr_d     = it_tmr_q;
      out_tmr_seq_d = (it_tmr_q != TMR_NONE) ? it_seq_q : '0;
      out_full_d    = full_q;
      out_base_d    = base_q;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WIN_RESET;
      state_q     <= ST_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      full_q      <= 1'b0;
      marks_q     <= '0;
      slide_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      full_q      <= full_d;
      marks_q     <= marks_d;
      slide_q     <= slide_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    it_acc_q      <= it_acc_d;
    it_tx_q       <= it_tx_d;
    it_exp_q      <= it_exp_d;
    it_seq_q      <= it_seq_d;
    it_payload_q  <= it_payload_d;
    it_tmr_q      <= it_tmr_d;
    out_acc_q     <= out_acc_d;
    out_tx_q      <= out_tx_d;
    out_tx_seq_q  <= out_tx_seq_d;
    out_payload_q <= out_payload_d;
    out_tmr_q     <= out_tmr_d;
    out_tmr_seq_q <= out_tmr_seq_d;
    out_full_q    <= out_full_d;
    out_base_q    <= out_base_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.accepted     = out_acc_q;
  assign res_o.transmit     = out_tx_q;
  assign res_o.tx_seq       = out_tx_seq_q;
  assign res_o.tx_payload   = out_payload_q;
  assign res_o.timer_action = out_tmr_q;
  assign res_o.timer_seq    = out_tmr_seq_q;
  assign res_o.window_full  = out_full_q;
  assign res_o.window_base  = out_base_q;

  // Checks
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_fire |=> (state_q == ST_EXEC))
    else $error("accepted transaction did not enter execution");

  a_slide_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && slide_q |-> (cnt_q <= win))
    else $error("window slide ran past the window size");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result appeared without an executing transaction");

  a_tx_has_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_tx_q |-> (out_tmr_q == TMR_START) || (out_tmr_q == TMR_RESTART))
    else $error("transmission without a timer start or restart");

  a_mark_cleared_on_slide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_go |=> !marks_q[$past(base_q)])
    else $error("slid entry kept its ack mark");

endmodule
